/* hdl/slcan_pkg.sv */
// slcan_pkg: shared constants, reply tables and the hex digit decoder for the
// slcan host byte parser. No dependencies.
package slcan_pkg;

  localparam logic [7:0] CH_START = 8'h74;  // 't'
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VER   = 8'h56;  // 'V'
  localparam logic [7:0] CH_SER   = 8'h76;  // 'v'
  localparam logic [7:0] FILL     = 8'hFF;

  localparam int unsigned MIN_FRAME_CHARS = 5;
  localparam int unsigned MAX_DLC         = 8;
  // last store position ever read: 't' iii l + 16 data digits
  localparam int unsigned DIG_LAST        = 20;

  typedef enum logic [1:0] {
    REP_VER,
    REP_SER,
    REP_CR
  } reply_kind_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  // index of the final byte of each reply string
  function automatic logic [2:0] reply_last_idx(input reply_kind_t k);
    logic [2:0] n;
    unique case (k)
      REP_VER: n = 3'd5;
      REP_SER: n = 3'd6;
      REP_CR:  n = 3'd0;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_char(input reply_kind_t k, input logic [2:0] idx);
    logic [7:0] b;
    b = CH_CR;
    unique case (k)
      REP_VER: begin
        case (idx)
          3'd0: b = 8'h56;
          3'd1: b = 8'h31;
          3'd2: b = 8'h30;
          3'd3: b = 8'h31;
          3'd4: b = 8'h30;
          default: b = CH_CR;
        endcase
      end
      REP_SER: begin
        case (idx)
          3'd0: b = 8'h76;
          3'd1: b = 8'h53;
          3'd2: b = 8'h54;
          3'd3: b = 8'h4D;
          3'd4: b = 8'h33;
          3'd5: b = 8'h32;
          default: b = CH_CR;
        endcase
      end
      REP_CR:  b = CH_CR;
      default: b = CH_CR;
    endcase
    return b;
  endfunction

endpackage

/* hdl/slcan_if.sv */
// slcan_if: valid/ready channel interfaces for the slcan host byte parser.
// Depends on nothing; the parser top uses all three.
interface slcan_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcan_res_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  reply_byte;
  logic        reply_last;
  logic [11:0] frame_ident;
  logic [3:0]  frame_length;
  logic [63:0] frame_payload;
  logic        frame_short;
  modport source (output valid, output out_kind, output reply_byte, output reply_last,
                  output frame_ident, output frame_length, output frame_payload,
                  output frame_short, input ready);
  modport sink   (input valid, input out_kind, input reply_byte, input reply_last,
                  input frame_ident, input frame_length, input frame_payload,
                  input frame_short, output ready);
endinterface

interface slcan_cfg_if;
  logic valid;
  logic ready;
  logic gateway_mode;
  modport source (output valid, output gateway_mode, input ready);
  modport sink   (input valid, input gateway_mode, output ready);
endinterface

/* hdl/slcan_host_byte_parser_top.sv */
// slcan_host_byte_parser_top: host byte parser, version replies or ascii frame decode.
// Depends on slcan_pkg and the channel interfaces in slcan_if.sv.
//
//  channel | dir | payload                                   | beat
//  rx      | in  | rx_byte                                   | one host byte
//  res     | out | out_kind, reply_byte, reply_last, frame_* | one reply byte or one frame
//  cfg     | in  | gateway_mode                              | one register write
//
// a byte sits in the input register and is handled there; results go to an output register
// gateway mode: one byte per cycle, a '\r' may wait for output; frame built in that cycle
// reply mode: one reply byte per cycle while output is free, 1 to 7 per byte ('v' gives 7)
// the reply step counter holds the input register until the last reply byte is loaded
// rst is synchronous; it clears the mode, the parser count and both valid flags
module slcan_host_byte_parser_top #(
  parameter int unsigned STORE_BYTES = 32
) (
  input logic          clk,
  input logic          rst,
  slcan_rx_if.sink     rx,
  slcan_res_if.source  res,
  slcan_cfg_if.sink    cfg
);
  import slcan_pkg::*;

  localparam int unsigned CW = $clog2(STORE_BYTES + 1);

  logic          gw;
  logic          hold_v;
  logic [7:0]    hold_byte;
  logic [2:0]    ridx;
  logic [CW-1:0] cc;
  logic [3:0]    dig [1:DIG_LAST];

  logic          o_v;
  logic          o_kind;
  logic [7:0]    o_byte;
  logic          o_last;
  logic [11:0]   o_ident;
  logic [3:0]    o_len;
  logic [63:0]   o_payload;
  logic          o_short;

  reply_kind_t   kind;
  logic          reply_done;
  logic          out_free;
  logic          is_start;
  logic          is_emit;
  logic          consume;
  logic          load_reply;
  logic          load_frame;
  logic [3:0]    dlc;
  logic [63:0]   payload_next;
  logic          short_next;
  logic [4:0]    last_pos;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (hold_byte == CH_VER) kind = REP_VER;
    else if (hold_byte == CH_SER) kind = REP_SER;
    else kind = REP_CR;
  end

  assign reply_done = (ridx == reply_last_idx(kind));
  assign out_free   = !o_v || res.ready;
  assign is_start   = (hold_byte == CH_START);
  assign is_emit    = !is_start && (cc != '0) && (hold_byte == CH_CR)
                      && (cc >= CW'(MIN_FRAME_CHARS));
  assign consume    = hold_v && (gw ? (!is_emit || out_free) : (out_free && reply_done));
  assign load_reply = hold_v && !gw && out_free;
  assign load_frame = hold_v && gw && is_emit && out_free;
  assign rx.ready   = !hold_v || consume;

  // frame decode from the stored digit nibbles
  assign dlc      = dig[4];
  assign last_pos = 5'd4 + {dlc, 1'b0};

  always_comb begin
    payload_next = '1;
    for (int i = 0; i < 8; i++) begin
      if (dlc <= 4'(MAX_DLC) && 4'(i) < dlc) begin
        payload_next[8*i +: 8] = {
          (CW'(5 + 2*i) < cc) ? dig[5 + 2*i] : 4'd0,
          (CW'(6 + 2*i) < cc) ? dig[6 + 2*i] : 4'd0
        };
      end
    end
    // missing digits: the last one dlc asks for lies at or past the count
    short_next = (dlc != 4'd0) && (dlc <= 4'(MAX_DLC)) && (CW'(last_pos) >= cc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gw     <= 1'b0;
      hold_v <= 1'b0;
      ridx   <= '0;
      cc     <= '0;
      o_v    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) gw <= cfg.gateway_mode;

      if (rx.valid && rx.ready) begin
        hold_v    <= 1'b1;
        hold_byte <= rx.rx_byte;
      end else if (consume) begin
        hold_v <= 1'b0;
      end

      if (load_reply) ridx <= reply_done ? 3'd0 : ridx + 3'd1;

      if (load_reply) begin
        o_v       <= 1'b1;
        o_kind    <= 1'b0;
        o_byte    <= reply_char(kind, ridx);
        o_last    <= reply_done;
        o_ident   <= '0;
        o_len     <= '0;
        o_payload <= '0;
        o_short   <= 1'b0;
      end else if (load_frame) begin
        o_v       <= 1'b1;
        o_kind    <= 1'b1;
        o_byte    <= '0;
        o_last    <= 1'b0;
        o_ident   <= {dig[1], dig[2], dig[3]};
        o_len     <= dlc;
        o_payload <= payload_next;
        o_short   <= short_next;
      end else if (res.ready) begin
        o_v <= 1'b0;
      end

      if (consume && gw) begin
        if (is_start) cc <= CW'(1);
        else if (cc == '0) cc <= cc;
        else if (is_emit) cc <= '0;
        else if (cc >= CW'(STORE_BYTES)) cc <= '0;  // overflow drops the frame
        else cc <= cc + CW'(1);
      end
    end
  end

  // digit store: only positions that a frame decode reads are kept
  for (genvar p = 1; p <= DIG_LAST; p++) begin : g_dig
    always_ff @(posedge clk) begin
      if (consume && gw && !is_start && !is_emit && cc == CW'(p)) begin
        dig[p] <= hex_value(hold_byte);
      end
    end
  end

  assign res.valid         = o_v;
  assign res.out_kind      = o_kind;
  assign res.reply_byte    = o_byte;
  assign res.reply_last    = o_last;
  assign res.frame_ident   = o_ident;
  assign res.frame_length  = o_len;
  assign res.frame_payload = o_payload;
  assign res.frame_short   = o_short;

  a_ridx_reply_only: assert property (@(posedge clk) disable iff (rst)
    ridx != 3'd0 |-> hold_v && !gw)
    else $error("reply step counter busy outside reply mode");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cc <= CW'(STORE_BYTES))
    else $error("parser count past store size");

  a_emit_idles: assert property (@(posedge clk) disable iff (rst)
    load_frame |=> cc == '0 && o_v && o_kind)
    else $error("frame emit did not idle the parser");

  a_reply_lands: assert property (@(posedge clk) disable iff (rst)
    load_reply |=> o_v && !o_kind)
    else $error("reply beat lost");

endmodule

/* test/tb_slcan_host_byte_parser_top.sv */
// tb_slcan_host_byte_parser_top: self-checking bench for the slcan host byte parser.
// Depends on slcan_pkg and the rx, res and cfg channel interfaces in slcan_if.sv.
// Predicts reply bytes and decoded frames per accepted host byte and checks every result beat.
module tb_slcan_host_byte_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slcan_pkg::*;

  localparam int unsigned STORE_DEPTH   = 32;
  localparam int unsigned MAX_IDLE      = 6;
  localparam int unsigned SETTLE_CYCLES = 16;

  // reply strings, first byte in the top bits
  localparam logic [47:0] VER_TEXT = {8'h56, 8'h31, 8'h30, 8'h31, 8'h30, 8'h0D};
  localparam logic [55:0] SER_TEXT = {8'h76, 8'h53, 8'h54, 8'h4D, 8'h33, 8'h32, 8'h0D};

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic [11:0] frame_ident;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic        frame_short;
  } parser_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slcan_rx_if  rx ();
  slcan_res_if res ();
  slcan_cfg_if cfg ();

  slcan_host_byte_parser_top #(
    .STORE_BYTES(STORE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res),
    .cfg(cfg)
  );

  always #6 clk = ~clk;

  // predictor state
  logic              gw_mode = 1'b0;
  logic [7:0]        frame_chars [STORE_DEPTH];
  int unsigned       chars_held = 0;
  parser_beat_t      awaited_beats [$];

  // stimulus and handshake state
  logic [7:0]        host_bytes [$];
  int unsigned       bytes_queued = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       rx_gap = 0;
  int unsigned       res_stall = 0;
  bit                rx_busy = 1'b0;
  bit                rx_calm = 1'b0;
  bit                res_calm = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
    return 4'd0;
  endfunction

  function automatic void push_reply(input logic [7:0] b, input logic last);
    parser_beat_t r;
    r = '0;
    r.reply_byte = b;
    r.reply_last = last;
    awaited_beats.push_back(r);
  endfunction

  function automatic void decode_frame_chars();
    parser_beat_t r;
    logic [3:0]   dlc;
    logic [7:0]   b;
    int unsigned  pos;
    r = '0;
    r.out_kind = 1'b1;
    r.frame_ident = {nibble_of(frame_chars[1]), nibble_of(frame_chars[2]),
                     nibble_of(frame_chars[3])};
    dlc = nibble_of(frame_chars[4]);
    r.frame_length = dlc;
    for (int i = 0; i < 8; i++) begin
      b = FILL;
      if (dlc <= MAX_DLC && i < dlc) begin
        b = 8'h00;
        for (int h = 0; h < 2; h++) begin
          pos = 5 + 2 * i + h;
          // digits past the end of what arrived read as zero
          if (pos < chars_held) begin
            b = {b[3:0], nibble_of(frame_chars[pos])};
          end else begin
            b = {b[3:0], 4'h0};
            r.frame_short = 1'b1;
          end
        end
      end
      r.frame_payload[8*i +: 8] = b;
    end
    awaited_beats.push_back(r);
  endfunction

  function automatic void parse_host_byte(input logic [7:0] c);
    if (!gw_mode) begin
      if (c == CH_VER) begin
        for (int k = 0; k < 6; k++) push_reply(VER_TEXT[8*(5-k) +: 8], k == 5);
      end else if (c == CH_SER) begin
        for (int k = 0; k < 7; k++) push_reply(SER_TEXT[8*(6-k) +: 8], k == 6);
      end else begin
        push_reply(CH_CR, 1'b1);
      end
    end else if (c == CH_START) begin
      frame_chars[0] = CH_START;
      chars_held = 1;
    end else if (chars_held == 0) begin
      // idle: byte ignored
    end else if (c == CH_CR && chars_held >= MIN_FRAME_CHARS) begin
      decode_frame_chars();
      chars_held = 0;
    end else if (chars_held >= STORE_DEPTH) begin
      chars_held = 0;
    end else begin
      frame_chars[chars_held] = c;
      chars_held++;
    end
  endfunction

  // host byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx_busy = 1'b0;
      rx_gap = $urandom_range(0, MAX_IDLE);
      rx.valid <= 1'b0;
    end else begin
      if (rx_busy && rx.ready) begin
        parse_host_byte(rx.rx_byte);
        rx_busy = 1'b0;
        if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
        rx_gap = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (!rx_busy) begin
        if (rx_gap > 0) begin
          rx_gap--;
        end else if (host_bytes.size() > 0) begin
          rx.rx_byte <= host_bytes.pop_front();
          rx_busy = 1'b1;
        end
      end
      rx.valid <= rx_busy;
    end
  end

  // result monitor
  always @(posedge clk) begin
    parser_beat_t want;
    if (rst) begin
      res_stall = 0;
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (awaited_beats.size() == 0) begin
          flag_mismatch("result beat with nothing awaited");
        end else begin
          want = awaited_beats.pop_front();
          if (res.out_kind !== want.out_kind)
            flag_mismatch($sformatf("out_kind got %0h want %0h", res.out_kind, want.out_kind));
          if (res.reply_byte !== want.reply_byte)
            flag_mismatch($sformatf("reply_byte got %0h want %0h",
                                    res.reply_byte, want.reply_byte));
          if (res.reply_last !== want.reply_last)
            flag_mismatch($sformatf("reply_last got %0h want %0h",
                                    res.reply_last, want.reply_last));
          if (res.frame_ident !== want.frame_ident)
            flag_mismatch($sformatf("frame_ident got %0h want %0h",
                                    res.frame_ident, want.frame_ident));
          if (res.frame_length !== want.frame_length)
            flag_mismatch($sformatf("frame_length got %0h want %0h",
                                    res.frame_length, want.frame_length));
          if (res.frame_payload !== want.frame_payload)
            flag_mismatch($sformatf("frame_payload got %016h want %016h",
                                    res.frame_payload, want.frame_payload));
          if (res.frame_short !== want.frame_short)
            flag_mismatch($sformatf("frame_short got %0h want %0h",
                                    res.frame_short, want.frame_short));
        end
        if ($urandom_range(0, 24) == 0) res_calm = !res_calm;
        res_stall = res_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (res.valid && res_stall > 0) begin
        res_stall--;
      end
      res.ready <= (res_stall == 0);
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    host_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s, input bit with_cr);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    if (with_cr) queue_byte(CH_CR);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1)) return 8'(8'h41 + v - 10);
    return 8'(8'h61 + v - 10);
  endfunction

  function automatic logic [7:0] rand_hex();
    return hex_char($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_START || c == CH_CR);
    return c;
  endfunction

  task automatic queue_random_frame();
    int unsigned pick, dlc, digits;
    pick = $urandom_range(0, 15);
    digits = 0;
    if (pick == 15) begin
      // noise, any byte value
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick == 14) begin
      // carriage return before the header is complete is stored as data
      queue_byte(CH_START);
      repeat ($urandom_range(0, 3)) queue_byte(rand_hex());
      queue_byte(CH_CR);
      repeat ($urandom_range(0, 6)) queue_byte(rand_hex());
      queue_byte(CH_CR);
      return;
    end
    queue_byte(CH_START);
    repeat (3) queue_byte(rand_hex());
    case (pick)
      9: begin
        dlc = $urandom_range(1, 8);
        digits = $urandom_range(0, 2 * dlc - 1);
      end
      10: begin
        dlc = $urandom_range(0, 7);
        digits = 2 * dlc + $urandom_range(1, 6);
      end
      11: begin
        dlc = $urandom_range(9, 15);
        digits = $urandom_range(0, 16);
      end
      default: begin
        dlc = $urandom_range(0, 8);
        digits = 2 * dlc;
      end
    endcase
    queue_byte(hex_char(dlc));
    if (pick == 12) begin
      repeat (2 * dlc) queue_byte($urandom_range(0, 1) ? junk_char() : rand_hex());
    end else if (pick == 13) begin
      // long enough to fill the store now and then
      repeat ($urandom_range(20, 32)) queue_byte(rand_hex());
    end else begin
      repeat (digits) queue_byte(rand_hex());
    end
    if (pick != 13 || $urandom_range(0, 1)) queue_byte(CH_CR);
  endtask

  task automatic queue_random_request();
    case ($urandom_range(0, 3))
      0:       queue_byte(CH_VER);
      1:       queue_byte(CH_SER);
      default: queue_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (host_bytes.size() != 0 || rx_busy || awaited_beats.size() != 0);
    // a byte that gives no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gateway_mode(input logic mode);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.gateway_mode <= mode;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    gw_mode = mode;
  endtask

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned target;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.gateway_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_gateway_mode(1'b0);
    queue_byte(CH_VER);
    queue_byte(CH_SER);
    queue_byte(CH_CR);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CH_START);
    wait_drained();

    write_gateway_mode(1'b1);
    queue_byte(8'h55);
    queue_byte(CH_CR);
    queue_text("t0000", 1'b1);
    queue_text("tFFF80123456789abcdef", 1'b1);
    queue_text("tABC31122", 1'b1);
    queue_text("t12", 1'b0);
    queue_text("t0012AA", 1'b1);
    queue_text("t12", 1'b1);
    queue_text("1", 1'b1);
    queue_text("t1119", 1'b1);
    queue_text("tG1z2zzq1", 1'b1);
    queue_text("t1231AABBCC", 1'b1);

    target = bytes_queued + 30;
    while (bytes_queued < target) queue_random_frame();
    // hold off the sender until everything is back
    wait_drained();
    target = bytes_queued + 30;
    while (bytes_queued < target) queue_random_frame();
    wait_drained();

    write_gateway_mode(1'b0);
    repeat (20) queue_random_request();
    wait_drained();

    write_gateway_mode(1'b1);
    target = bytes_queued + 25;
    while (bytes_queued < target) queue_random_frame();
    wait_drained();

    write_gateway_mode(1'b0);
    repeat (10) queue_random_request();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
